/* sv/weighted_astar_open_list_top_assert.svh */
// Assertion macros for the weighted A* open list.
// Used by the top level; no other dependencies.
`ifndef WEIGHTED_ASTAR_OPEN_LIST_TOP_ASSERT_SVH
`define WEIGHTED_ASTAR_OPEN_LIST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WAOL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WAOL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WAOL_ASSERT(lbl, prop, msg)
`define WAOL_NEVER(lbl, cond, msg)
`endif
`endif

/* sv/waol_pkg.sv */
// Shared types, codes and the heap ordering function for the open list.
// No dependencies.
package waol_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int MAX_HEUR     = 4;
    localparam int QDEPTH       = 2;

    localparam logic       FUNC_PUSH = 1'b0;
    localparam logic       FUNC_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] CFG_WEIGHT = 2'd0;
    localparam logic [1:0] CFG_GMODE  = 2'd1;
    localparam logic [1:0] CFG_HUSED  = 2'd2;

    localparam logic [1:0] G_NONE   = 2'd0;
    localparam logic [1:0] G_DEPTH  = 2'd1;
    localparam logic [1:0] G_COST   = 2'd2;
    localparam logic [1:0] G_MIXED  = 2'd3;

    // one heap slot: f key, tie heuristics, random tag over node id
    typedef struct packed {
        logic [23:0] fkey;
        logic [47:0] ties;
        logic [31:0] rid;
    } ent_t;

    // one classified operation between front and back
    typedef struct packed {
        logic func;
        ent_t ent;
    } cmd_t;

    // strict ordering of two slots
    function automatic logic ent_less(ent_t a, ent_t b, logic [2:0] used);
        logic        res;
        logic        decided;
        logic [15:0] ta;
        logic [15:0] tb;
        res     = 1'b0;
        decided = 1'b0;
        if (a.fkey != b.fkey)
        begin
            res     = a.fkey < b.fkey;
            decided = 1'b1;
        end
        for (int k = 1; k < MAX_HEUR; k++)
        begin
            ta = a.ties[16*(k-1) +: 16];
            tb = b.ties[16*(k-1) +: 16];
            if (!decided && (3'(k) < used) && (ta != tb))
            begin
                res     = ta < tb;
                decided = 1'b1;
            end
        end
        if (!decided)
            res = a.rid < b.rid;
        return res;
    endfunction

endpackage

/* sv/waol_front.sv */
// Front end: takes input beats, computes f and packs a heap command.
// Depends on waol_pkg.
module waol_front import waol_pkg::*;
(
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [15:0] node_id,
    input  logic [15:0] h_primary,
    input  logic [15:0] h_tie_one,
    input  logic [15:0] h_tie_two,
    input  logic [15:0] h_tie_three,
    input  logic [15:0] path_depth,
    input  logic [15:0] action_cost,
    input  logic [15:0] mixed_depth,
    input  logic [15:0] tie_rand,
    input  logic [7:0]  weight,
    input  logic [1:0]  g_mode,
    output logic        q_wvalid,
    input  logic        q_wready,
    output cmd_t        q_wcmd
);

    logic [15:0] g_sel;
    logic [23:0] prod;

    // pick the g term
    always_comb
    begin
        unique case (g_mode)
            G_NONE:  g_sel = 16'd0;
            G_DEPTH: g_sel = path_depth;
            G_COST:  g_sel = action_cost;
            G_MIXED: g_sel = mixed_depth;
            default: g_sel = 16'd0;
        endcase
    end

    assign prod = 24'(h_primary) * 24'(weight);

    // pack the command
    always_comb
    begin
        q_wcmd.func     = func;
        q_wcmd.ent.fkey = prod + 24'(g_sel);
        q_wcmd.ent.ties = {h_tie_three, h_tie_two, h_tie_one};
        q_wcmd.ent.rid  = {tie_rand, node_id};
    end

    assign q_wvalid = in_valid;
    assign in_ready = q_wready;

endmodule

/* sv/waol_queue.sv */
// Short command queue between front and back.
// Depends on waol_pkg.
module waol_queue import waol_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wvalid,
    output logic wready,
    input  cmd_t wcmd,
    output logic rvalid,
    input  logic rready,
    output cmd_t rcmd
);

    localparam int PW = $clog2(QDEPTH);

    cmd_t              mem_reg [QDEPTH];
    logic [PW-1:0]     wptr_reg;
    logic [PW-1:0]     rptr_reg;
    logic [PW:0]       fill_reg;
    logic              do_w;
    logic              do_r;

    assign wready = fill_reg != (PW+1)'(QDEPTH);
    assign rvalid = fill_reg != '0;
    assign rcmd   = mem_reg[rptr_reg];
    assign do_w   = wvalid && wready;
    assign do_r   = rvalid && rready;

    // store beats
    always_ff @(posedge clk)
    begin
        if (do_w)
            mem_reg[wptr_reg] <= wcmd;
    end

    // advance pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_w)
                wptr_reg <= (wptr_reg == PW'(QDEPTH-1)) ? '0 : wptr_reg + 1'b1;
            if (do_r)
                rptr_reg <= (rptr_reg == PW'(QDEPTH-1)) ? '0 : rptr_reg + 1'b1;
            if (do_w && !do_r)
                fill_reg <= fill_reg + 1'b1;
            else if (do_r && !do_w)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

/* sv/waol_back.sv */
// Back end: heap memory and sift sequencer, plus the result register.
// Depends on waol_pkg.
module waol_back import waol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [2:0]       h_used,
    input  logic             q_valid,
    output logic             q_ready,
    input  cmd_t             q_cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_node_id,
    output logic [23:0]      f_value,
    output logic [1:0]       status,
    output logic [CNT_W-1:0] count,
    output logic             is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int XW = AW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UCMP  = 4'd1;
    localparam logic [3:0] S_WFIN  = 4'd2;
    localparam logic [3:0] S_PTOP  = 4'd3;
    localparam logic [3:0] S_PLAST = 4'd4;
    localparam logic [3:0] S_DST   = 4'd5;
    localparam logic [3:0] S_DL    = 4'd6;
    localparam logic [3:0] S_DR    = 4'd7;
    localparam logic [3:0] S_DCMP  = 4'd8;

    ent_t             heap_mem [CAPACITY];
    ent_t             rdata_reg;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]    pos_reg, pos_next;
    ent_t             cur_reg, cur_next;
    ent_t             best_reg, best_next;
    logic [AW-1:0]    bidx_reg, bidx_next;
    logic [15:0]      rid_reg, rid_next;
    logic [23:0]      rf_reg, rf_next;
    logic             ov_reg, ov_next;
    logic [15:0]      oid_reg, oid_next;
    logic [23:0]      of_reg, of_next;
    logic [1:0]       ost_reg, ost_next;

    logic             re;
    logic [AW-1:0]    raddr;
    logic             we;
    logic [AW-1:0]    waddr;
    ent_t             wdata;
    logic [2:0]       used_eff;
    logic [AW-1:0]    par_pos;
    logic [XW-1:0]    left_x;
    logic [XW-1:0]    right_x;
    logic [XW-1:0]    cnt_x;
    logic [CNT_W-1:0] cnt_dec;

    assign used_eff = (h_used > 3'(MAX_HEUR)) ? 3'(MAX_HEUR) : h_used;
    assign par_pos  = (pos_reg - 1'b1) >> 1;
    assign left_x   = {1'b0, pos_reg, 1'b1};
    assign right_x  = left_x + 1'b1;
    assign cnt_x    = XW'(cnt_reg);
    assign cnt_dec  = cnt_reg - 1'b1;

    // heap memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            heap_mem[waddr] <= wdata;
        if (re)
            rdata_reg <= heap_mem[raddr];
    end

    // sift sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        rid_next   = rid_reg;
        rf_next    = rf_reg;
        ov_next    = ov_reg;
        oid_next   = oid_reg;
        of_next    = of_reg;
        ost_next   = ost_reg;
        re         = 1'b0;
        raddr      = '0;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = cur_reg;
        q_ready    = 1'b0;

        // drop the result once taken
        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    q_ready = 1'b1;
                    if (q_cmd.func == FUNC_POP)
                    begin
                        if (cnt_reg == '0)
                        begin
                            ov_next  = 1'b1;
                            oid_next = 16'd0;
                            of_next  = 24'd0;
                            ost_next = ST_EMPTY;
                        end
                        else
                        begin
                            re         = 1'b1;
                            raddr      = '0;
                            state_next = S_PTOP;
                        end
                    end
                    else if (cnt_reg == CNT_W'(CAPACITY))
                    begin
                        ov_next  = 1'b1;
                        oid_next = q_cmd.ent.rid[15:0];
                        of_next  = q_cmd.ent.fkey;
                        ost_next = ST_FULL;
                    end
                    else
                    begin
                        cur_next = q_cmd.ent;
                        rid_next = q_cmd.ent.rid[15:0];
                        rf_next  = q_cmd.ent.fkey;
                        cnt_next = cnt_reg + 1'b1;
                        pos_next = cnt_reg[AW-1:0];
                        if (cnt_reg == '0)
                        begin
                            state_next = S_WFIN;
                        end
                        else
                        begin
                            re         = 1'b1;
                            raddr      = (cnt_reg[AW-1:0] - 1'b1) >> 1;
                            state_next = S_UCMP;
                        end
                    end
                end
            end
            S_UCMP:
            begin
                // move the parent down while the new entry is less
                if (ent_less(cur_reg, rdata_reg, used_eff))
                begin
                    we       = 1'b1;
                    wdata    = rdata_reg;
                    pos_next = par_pos;
                    if (par_pos == '0)
                    begin
                        state_next = S_WFIN;
                    end
                    else
                    begin
                        re    = 1'b1;
                        raddr = (par_pos - 1'b1) >> 1;
                    end
                end
                else
                begin
                    state_next = S_WFIN;
                end
            end
            S_WFIN:
            begin
                we         = 1'b1;
                ov_next    = 1'b1;
                oid_next   = rid_reg;
                of_next    = rf_reg;
                ost_next   = ST_OK;
                state_next = S_IDLE;
            end
            S_PTOP:
            begin
                rid_next = rdata_reg.rid[15:0];
                rf_next  = rdata_reg.fkey;
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    ov_next    = 1'b1;
                    oid_next   = rdata_reg.rid[15:0];
                    of_next    = rdata_reg.fkey;
                    ost_next   = ST_OK;
                    state_next = S_IDLE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = cnt_dec[AW-1:0];
                    state_next = S_PLAST;
                end
            end
            S_PLAST:
            begin
                cur_next   = rdata_reg;
                pos_next   = '0;
                state_next = S_DST;
            end
            S_DST:
            begin
                if (left_x >= cnt_x)
                begin
                    state_next = S_WFIN;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = left_x[AW-1:0];
                    state_next = S_DL;
                end
            end
            S_DL:
            begin
                best_next = rdata_reg;
                bidx_next = left_x[AW-1:0];
                if (right_x < cnt_x)
                begin
                    re         = 1'b1;
                    raddr      = right_x[AW-1:0];
                    state_next = S_DR;
                end
                else
                begin
                    state_next = S_DCMP;
                end
            end
            S_DR:
            begin
                // take the right child only if strictly less
                if (ent_less(rdata_reg, best_reg, used_eff))
                begin
                    best_next = rdata_reg;
                    bidx_next = right_x[AW-1:0];
                end
                state_next = S_DCMP;
            end
            S_DCMP:
            begin
                if (ent_less(best_reg, cur_reg, used_eff))
                begin
                    we         = 1'b1;
                    wdata      = best_reg;
                    pos_next   = bidx_reg;
                    state_next = S_DST;
                end
                else
                begin
                    state_next = S_WFIN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    // payload holding
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        cur_reg  <= cur_next;
        best_reg <= best_next;
        bidx_reg <= bidx_next;
        rid_reg  <= rid_next;
        rf_reg   <= rf_next;
        oid_reg  <= oid_next;
        of_reg   <= of_next;
        ost_reg  <= ost_next;
    end

    assign out_valid   = ov_reg;
    assign out_node_id = oid_reg;
    assign f_value     = of_reg;
    assign status      = ost_reg;
    assign count       = cnt_reg;
    assign is_empty    = cnt_reg == '0;

endmodule

/* sv/weighted_astar_open_list_top.sv */
// Weighted A* open list top level: config registers, front, queue, back.
// Depends on waol_pkg, waol_front, waol_queue, waol_back and the assert header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | func, node_id, heuristics, g values, tag
//  result   | out_valid/ out_ready | out_node_id, f_value, status, count, ...
//  config   | cfg_we               | cfg_index, cfg_data
//
// A push on an empty heap writes its slot directly; else it compares with one
// parent after another, moving each down, until it finds its place. A pop reads
// the top; with one entry that is the result, else it sinks the last entry from
// the top, reading each child through the single read port of the heap memory.
// Empty pops and full pushes load the result register with no heap access.
// Reset clears the entry count, the queue and the result valid flag.
// The two-entry queue takes input beats while the back end works or stalls,
// until it holds two; a waiting result stalls the back end.
`include "weighted_astar_open_list_top_assert.svh"
module weighted_astar_open_list_top import waol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             func,
    input  logic [15:0]      node_id,
    input  logic [15:0]      h_primary,
    input  logic [15:0]      h_tie_one,
    input  logic [15:0]      h_tie_two,
    input  logic [15:0]      h_tie_three,
    input  logic [15:0]      path_depth,
    input  logic [15:0]      action_cost,
    input  logic [15:0]      mixed_depth,
    input  logic [15:0]      tie_rand,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_node_id,
    output logic [23:0]      f_value,
    output logic [1:0]       status,
    output logic [CNT_W-1:0] count,
    output logic             is_empty
);

    logic [7:0] weight_reg;
    logic [1:0] gmode_reg;
    logic [2:0] hused_reg;
    logic       qw_valid;
    logic       qw_ready;
    cmd_t       qw_cmd;
    logic       qr_valid;
    logic       qr_ready;
    cmd_t       qr_cmd;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= 8'd1;
            gmode_reg  <= 2'd1;
            hused_reg  <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WEIGHT: weight_reg <= cfg_data;
                CFG_GMODE:  gmode_reg  <= cfg_data[1:0];
                CFG_HUSED:  hused_reg  <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    waol_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .node_id     (node_id),
        .h_primary   (h_primary),
        .h_tie_one   (h_tie_one),
        .h_tie_two   (h_tie_two),
        .h_tie_three (h_tie_three),
        .path_depth  (path_depth),
        .action_cost (action_cost),
        .mixed_depth (mixed_depth),
        .tie_rand    (tie_rand),
        .weight      (weight_reg),
        .g_mode      (gmode_reg),
        .q_wvalid    (qw_valid),
        .q_wready    (qw_ready),
        .q_wcmd      (qw_cmd)
    );

    waol_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wvalid (qw_valid),
        .wready (qw_ready),
        .wcmd   (qw_cmd),
        .rvalid (qr_valid),
        .rready (qr_ready),
        .rcmd   (qr_cmd)
    );

    waol_back #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .h_used      (hused_reg),
        .q_valid     (qr_valid),
        .q_ready     (qr_ready),
        .q_cmd       (qr_cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_node_id (out_node_id),
        .f_value     (f_value),
        .status      (status),
        .count       (count),
        .is_empty    (is_empty)
    );

    // checks
    `WAOL_ASSERT(a_empty_pop, out_valid && status == ST_EMPTY |-> count == '0 && f_value == 24'd0, "empty pop must report zero count and f")
    `WAOL_ASSERT(a_full_push, out_valid && status == ST_FULL |-> count == CNT_W'(CAPACITY), "full push with count below capacity")
    `WAOL_NEVER(a_count_range, count > CNT_W'(CAPACITY), "entry count above capacity")

endmodule

/* tb/weighted_astar_open_list_checker.sv */
// Result checker for the weighted A* open list: predicts each result from its own heap copy.
// Depends on waol_pkg for the operation, status and register codes.
module weighted_astar_open_list_checker import waol_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic [15:0] node_id,
    input  logic [15:0] h_primary,
    input  logic [15:0] h_tie_one,
    input  logic [15:0] h_tie_two,
    input  logic [15:0] h_tie_three,
    input  logic [15:0] path_depth,
    input  logic [15:0] action_cost,
    input  logic [15:0] mixed_depth,
    input  logic [15:0] tie_rand,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] out_node_id,
    input  logic [23:0] f_value,
    input  logic [1:0]  status,
    input  logic [8:0]  count,
    input  logic        is_empty,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 256;

    typedef struct packed {
        logic [23:0] f;
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] tag;
        logic [15:0] id;
    } node_t;

    typedef struct packed {
        logic [15:0] id;
        logic [23:0] f;
        logic [1:0]  st;
        logic [8:0]  cnt;
        logic        emp;
    } result_t;

    node_t     open_heap[SLOTS];
    int        held;
    logic [7:0] weight;
    logic [1:0] g_sel;
    logic [2:0] ties_used;
    result_t   expected_q[$];
    int        err_cnt;

    // true when a sorts strictly ahead of b under the current tie count
    function automatic bit sorts_first(node_t a, node_t b);
        int n;
        logic [15:0] ka[3];
        logic [15:0] kb[3];
        n = (ties_used > 3'd4) ? 4 : int'(ties_used);
        ka = '{a.t1, a.t2, a.t3};
        kb = '{b.t1, b.t2, b.t3};
        if (a.f != b.f)
            return a.f < b.f;
        for (int k = 1; k < n; k++)
        begin
            if (ka[k-1] != kb[k-1])
                return ka[k-1] < kb[k-1];
        end
        return {a.tag, a.id} < {b.tag, b.id};
    endfunction

    function automatic void swap_nodes(int a, int b);
        node_t tmp;
        tmp = open_heap[a];
        open_heap[a] = open_heap[b];
        open_heap[b] = tmp;
    endfunction

    // advance the heap copy by one beat and return its result
    function automatic result_t open_list_step();
        result_t r;
        node_t   n;
        logic [15:0] g;
        int pos;
        int kid;
        r = '0;
        if (func == FUNC_PUSH)
        begin
            case (g_sel)
                G_DEPTH: g = path_depth;
                G_COST:  g = action_cost;
                G_MIXED: g = mixed_depth;
                default: g = 16'd0;
            endcase
            r.id = node_id;
            r.f  = 24'(h_primary) * 24'(weight) + 24'(g);
            if (held >= SLOTS)
                r.st = ST_FULL;
            else
            begin
                r.st = ST_OK;
                n = '{r.f, h_tie_one, h_tie_two, h_tie_three, tie_rand, node_id};
                pos = held;
                open_heap[pos] = n;
                held++;
                while (pos > 0 && sorts_first(open_heap[pos], open_heap[(pos-1)/2]))
                begin
                    swap_nodes(pos, (pos-1)/2);
                    pos = (pos-1)/2;
                end
            end
        end
        else if (held == 0)
            r.st = ST_EMPTY;
        else
        begin
            r.st = ST_OK;
            r.id = open_heap[0].id;
            r.f  = open_heap[0].f;
            held--;
            if (held > 0)
                open_heap[0] = open_heap[held];
            pos = 0;
            while (2*pos + 1 < held)
            begin
                kid = 2*pos + 1;
                if (kid + 1 < held && sorts_first(open_heap[kid+1], open_heap[kid]))
                    kid = kid + 1;
                if (!sorts_first(open_heap[kid], open_heap[pos]))
                    break;
                swap_nodes(kid, pos);
                pos = kid;
            end
        end
        r.cnt = 9'(held);
        r.emp = (held == 0);
        return r;
    endfunction

    // track registers, predict on input beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            held      = 0;
            weight    = 8'd1;
            g_sel     = G_DEPTH;
            ties_used = 3'd1;
            expected_q.delete();
            err_cnt   = 0;
            errors   <= 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WEIGHT: weight    = cfg_data;
                    CFG_GMODE:  g_sel     = cfg_data[1:0];
                    CFG_HUSED:  ties_used = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_q.push_back(open_list_step());
            if (out_valid && out_ready)
            begin
                got = '{out_node_id, f_value, status, count, is_empty};
                if (expected_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected result beat id=%h f=%h st=%0d cnt=%0d",
                                 $realtime, out_node_id, f_value, status, count);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got != want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: mismatch id %h/%h f %h/%h st %0d/%0d cnt %0d/%0d emp %b/%b (exp/act)",
                                     $realtime, want.id, got.id, want.f, got.f, want.st, got.st,
                                     want.cnt, got.cnt, want.emp, got.emp);
                    end
                end
            end
            errors  <= err_cnt;
            pending <= expected_q.size();
        end
    end

endmodule

/* tb/weighted_astar_open_list_top_tb.sv */
// Testbench top for the weighted A* open list: clock, reset, stimulus, verdict.
// Depends on waol_pkg, weighted_astar_open_list_top and weighted_astar_open_list_checker.
module weighted_astar_open_list_top_tb import waol_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY_WAIT = 80;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic        op;
        logic [15:0] id;
        logic [15:0] hp;
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] gd;
        logic [15:0] gc;
        logic [15:0] gm;
        logic [15:0] tag;
    } node_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [15:0] node_id, h_primary, h_tie_one, h_tie_two, h_tie_three;
    logic [15:0] path_depth, action_cost, mixed_depth, tie_rand;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_node_id;
    logic [23:0] f_value;
    logic [1:0]  status;
    logic [8:0]  count;
    logic        is_empty;
    int          errors;
    int          pending;
    bit          hold_req;
    int          burst_left;
    int          idle_cycles = 0;

    weighted_astar_open_list_top DUT (.*);
    weighted_astar_open_list_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random node; narrow values crowd the keys so ties get exercised
    function automatic node_beat_t rand_node(int push_pct);
        node_beat_t b;
        bit narrow;
        narrow = ($urandom_range(0, 1) == 1);
        b.op  = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
        b.id  = narrow ? 16'($urandom_range(0, 7)) : 16'($urandom);
        b.hp  = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        b.t1  = narrow ? 16'($urandom_range(0, 2)) : 16'($urandom);
        b.t2  = narrow ? 16'($urandom_range(0, 2)) : 16'($urandom);
        b.t3  = narrow ? 16'($urandom_range(0, 2)) : 16'($urandom);
        b.gd  = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        b.gc  = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        b.gm  = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        b.tag = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
        return b;
    endfunction

    // offer one beat, hold it until accepted, then gap per the burst pattern
    task automatic send_node(node_beat_t b);
        in_valid    <= 1'b1;
        func        <= b.op;
        node_id     <= b.id;
        h_primary   <= b.hp;
        h_tie_one   <= b.t1;
        h_tie_two   <= b.t2;
        h_tie_three <= b.t3;
        path_depth  <= b.gd;
        action_cost <= b.gc;
        mixed_depth <= b.gm;
        tie_rand    <= b.tag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    endtask

    // write a register once every result has come and the block has settled
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_push(logic [15:0] id, logic [15:0] hp, logic [15:0] t1,
                             logic [15:0] tag);
        send_node('{FUNC_PUSH, id, hp, t1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, tag});
    endtask

    task automatic send_pop();
        send_node('{FUNC_POP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    endtask

    // receiver: stall patterns redrawn at random from four modes, plus one long hold
    initial
    begin
        int mode;
        int cyc;
        bit hold_done;
        out_ready <= 1'b0;
        mode      = 0;
        cyc       = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            cyc++;
            if (cyc % 300 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 9) != 0);
                default: out_ready <= ((cyc % 7) < 3);
            endcase
        end
    end

    // watchdog: count cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL weighted_astar_open_list_top");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] weights[6] = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd2, 8'd17};
        logic [1:0] gmodes[6]  = '{G_MIXED, G_DEPTH, G_NONE, G_COST, G_MIXED, G_DEPTH};
        logic [2:0] hused[6]   = '{3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd5};
        node_beat_t b;
        rst_n       = 1'b0;
        burst_left  = 0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_WEIGHT;
        cfg_data    <= 8'd0;
        in_valid    <= 1'b0;
        func        <= FUNC_PUSH;
        {node_id, h_primary, h_tie_one, h_tie_two, h_tie_three} <= '0;
        {path_depth, action_cost, mixed_depth, tie_rand} <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, reset settings, then extremes and ties
        send_pop();
        send_push(16'h0005, 16'd10, 16'd0, 16'd0);
        send_pop();
        send_pop();
        write_reg(CFG_WEIGHT, 8'd255);
        write_reg(CFG_GMODE, 8'(G_MIXED));
        write_reg(CFG_HUSED, 8'd4);
        send_node('{FUNC_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_node('0);
        send_push(16'h0009, 16'd0, 16'd4, 16'd1);
        send_push(16'h0003, 16'd0, 16'd4, 16'd1);
        send_push(16'h0007, 16'd0, 16'd4, 16'd0);
        send_push(16'h0001, 16'd0, 16'd2, 16'd9);
        repeat (7) send_pop();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_WEIGHT, (ph == 5) ? 8'($urandom) : weights[ph]);
            write_reg(CFG_GMODE, 8'(gmodes[ph]));
            write_reg(CFG_HUSED, 8'(hused[ph]));
            if (ph == 2)
            begin
                // fill past capacity, then drain past empty
                for (int i = 0; i < 262; i++)
                begin
                    b = rand_node(100);
                    send_node(b);
                end
                for (int i = 0; i < 262; i++)
                begin
                    b = rand_node(0);
                    send_node(b);
                end
            end
            else
            begin
                for (int i = 0; i < 140; i++)
                begin
                    if (ph == 1 && i == 40)
                        hold_req = 1'b1;
                    b = rand_node((ph % 2 == 0) ? 60 : 45);
                    send_node(b);
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
        if (errors == 0)
            $display("PASS weighted_astar_open_list_top");
        else
            $display("FAIL weighted_astar_open_list_top");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/waol_pkg.sv
sv/waol_front.sv
sv/waol_queue.sv
sv/waol_back.sv
sv/weighted_astar_open_list_top.sv
tb/weighted_astar_open_list_checker.sv
tb/weighted_astar_open_list_top_tb.sv
